[hdl/ttcw_pkg.sv]
// Package for the character-cell screen writer: item structs, register indexes,
// default maximum sizes, request types and control codes. No dependencies.
package ttcw_pkg;

    localparam int DEF_MAX_ROWS    = 32;
    localparam int DEF_MAX_COLUMNS = 128;

    // register indexes
    localparam logic [2:0] REG_COLUMNS = 3'd0;
    localparam logic [2:0] REG_ROWS    = 3'd1;
    localparam logic [2:0] REG_TOP     = 3'd2;
    localparam logic [2:0] REG_BOTTOM  = 3'd3;
    localparam logic [2:0] REG_CRLF    = 3'd4;
    localparam logic [2:0] REG_ATTR    = 3'd5;
    localparam logic [2:0] REG_FG      = 3'd6;
    localparam logic [2:0] REG_BG      = 3'd7;

    // request types
    localparam logic [1:0] REQ_PUT  = 2'd0;
    localparam logic [1:0] REQ_READ = 2'd1;
    localparam logic [1:0] REQ_ACK  = 2'd2;

    // control codes
    localparam logic [20:0] CH_BS    = 21'h08;
    localparam logic [20:0] CH_LF    = 21'h0a;
    localparam logic [20:0] CH_VT    = 21'h0b;
    localparam logic [20:0] CH_FF    = 21'h0c;
    localparam logic [20:0] CH_CR    = 21'h0d;
    localparam logic [20:0] CH_SUB   = 21'h1a;
    localparam logic [20:0] CH_DEL   = 21'h7f;
    localparam logic [20:0] CH_NEL   = 21'h85;
    localparam logic [20:0] CH_C0MAX = 21'h1f;
    localparam logic [20:0] CH_C1MIN = 21'h80;
    localparam logic [20:0] CH_C1MAX = 21'h9f;
    localparam logic [20:0] CH_QUERY = 21'h3f;
    localparam logic [20:0] CH_SPACE = 21'h20;

    typedef struct packed {
        logic [1:0]  req_type;
        logic [20:0] char_code;
        logic [4:0]  cell_row;
        logic [6:0]  cell_column;
    } req_item_t;

    typedef struct packed {
        logic [20:0] glyph_code;
        logic [10:0] glyph_attributes;
        logic [31:0] glyph_foreground;
        logic [31:0] glyph_background;
        logic        line_dirty;
        logic [6:0]  cursor_x;
        logic [4:0]  cursor_y;
    } rsp_item_t;

endpackage

[hdl/text_terminal_character_writer.sv]
// Character-cell screen writer top level: sequencer, row map, dirty marks, cell RAM.
// Depends on ttcw_pkg and ttcw_ram.
//
// One item at a time. After reset the block sweeps the cell memory once, one
// cell a cycle, writing spaces and zero colours; no item is taken then. An
// acknowledge, an unused request or a put without a newline passes only the
// done state before the result; a read passes the address register and the
// memory read, and a put that makes a newline passes the row step first.
// A newline on the scroll bottom also clears the leaving line one cell a cycle
// through the single memory write port; the row-map rotation is done together
// with the last cell write. The result sits in an output register and no new
// item is taken while a waiting result is stalled.
module text_terminal_character_writer
    import ttcw_pkg::*;
(
    input  logic      clk,
    input  logic      rst_n,
    input  logic      cfg_we,
    input  logic [2:0] cfg_index,
    input  logic [31:0] cfg_data,
    input  logic      in_valid,
    output logic      in_stall,
    input  req_item_t in_item,
    output logic      out_valid,
    input  logic      out_stall,
    output rsp_item_t out_item
);
    localparam int MAX_ROWS    = DEF_MAX_ROWS;
    localparam int MAX_COLUMNS = DEF_MAX_COLUMNS;
    localparam int RW    = $clog2(MAX_ROWS);
    localparam int CW    = $clog2(MAX_COLUMNS);
    localparam int AW    = RW + CW;
    localparam int DEPTH = MAX_ROWS * MAX_COLUMNS;
    localparam logic [8:0] MAXC = 9'(MAX_COLUMNS);
    localparam logic [6:0] MAXR = 7'(MAX_ROWS);

    // state codes
    localparam logic [2:0] S_INIT  = 3'd0;
    localparam logic [2:0] S_IDLE  = 3'd1;
    localparam logic [2:0] S_READ  = 3'd2;
    localparam logic [2:0] S_CLEAR = 3'd3;
    localparam logic [2:0] S_ROT   = 3'd4;
    localparam logic [2:0] S_DONE  = 3'd5;
    localparam logic [2:0] S_RWAIT = 3'd6;

    // configuration registers
    logic [7:0]  cols_reg;
    logic [5:0]  rows_reg;
    logic [4:0]  top_reg, bot_reg;
    logic        crlf_reg;
    logic [10:0] attr_reg;
    logic [31:0] fg_reg, bg_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cols_reg <= 8'd80;
            rows_reg <= 6'd24;
            top_reg  <= '0;
            bot_reg  <= 5'd23;
            crlf_reg <= 1'b0;
            attr_reg <= '0;
            fg_reg   <= '0;
            bg_reg   <= '0;
        end
        else if (cfg_we)
        begin
            unique case (cfg_index)
                REG_COLUMNS: cols_reg <= cfg_data[7:0];
                REG_ROWS:    rows_reg <= cfg_data[5:0];
                REG_TOP:     top_reg  <= cfg_data[4:0];
                REG_BOTTOM:  bot_reg  <= cfg_data[4:0];
                REG_CRLF:    crlf_reg <= cfg_data[0];
                REG_ATTR:    attr_reg <= cfg_data[10:0];
                REG_FG:      fg_reg   <= cfg_data;
                REG_BG:      bg_reg   <= cfg_data;
                default: ;
            endcase
        end
    end

    // effective sizes and scroll region (widened for parameter range)
    logic [8:0] eff_cols, cmax;
    logic [6:0] eff_rows, rmax, ebot, etop;
    always_comb
    begin
        eff_cols = (cols_reg == 8'd0) ? 9'd1 : ({1'b0, cols_reg} > MAXC ? MAXC : {1'b0, cols_reg});
        eff_rows = (rows_reg == 6'd0) ? 7'd1 : ({1'b0, rows_reg} > MAXR ? MAXR : {1'b0, rows_reg});
        cmax = eff_cols - 9'd1;
        rmax = eff_rows - 7'd1;
        ebot = ({2'b0, bot_reg} > rmax) ? rmax : {2'b0, bot_reg};
        etop = ({2'b0, top_reg} > ebot) ? ebot : {2'b0, top_reg};
    end

    // row map and dirty marks in flip-flops
    logic [RW-1:0] map_reg [MAX_ROWS];
    logic [MAX_ROWS-1:0] dirty_reg;

    // control
    logic [2:0]  state_reg;
    logic [AW-1:0] sweep_reg;
    logic [6:0]  col_reg;
    logic [4:0]  row_reg;
    logic [6:0]  idx_reg;
    logic [RW-1:0] first_reg;
    logic        nl_first_reg;
    logic [6:0]  ny_reg;
    logic        out_valid_reg;
    rsp_item_t   out_reg;
    logic [7:0]  rd_row_reg;
    logic [7:0]  rd_col_reg;

    logic            ram_we;
    logic [AW-1:0]   ram_waddr, ram_raddr;
    logic [95:0]     ram_wdata, ram_rdata;

    ttcw_ram #(.WIDTH(96), .DEPTH(DEPTH)) u_cells (
        .clk   (clk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (ram_wdata),
        .raddr (ram_raddr),
        .rdata (ram_rdata)
    );

    wire take = (state_reg == S_IDLE) && in_valid && !(out_valid_reg && out_stall);
    assign in_stall  = !((state_reg == S_IDLE) && !(out_valid_reg && out_stall));
    assign out_valid = out_valid_reg;
    assign out_item  = out_reg;

    // clamp cursor and request coordinates
    logic [6:0] ccol, crow_w, qrow;
    logic [8:0] qcol;
    logic [4:0] crow;
    always_comb
    begin
        ccol   = ({2'b0, col_reg} > cmax) ? cmax[6:0] : col_reg;
        crow_w = ({2'b0, row_reg} > rmax) ? rmax : {2'b0, row_reg};
        crow   = crow_w[4:0];
        qrow   = ({2'b0, in_item.cell_row} > rmax) ? rmax : {2'b0, in_item.cell_row};
        qcol   = ({2'b0, in_item.cell_column} > cmax) ? cmax : {2'b0, in_item.cell_column};
    end

    function automatic logic [CW-1:0] colidx(input logic [8:0] c);
        logic [8:0] m;
        m = (c >= MAXC) ? MAXC - 9'd1 : c;
        return m[CW-1:0];
    endfunction

    logic [20:0] code;
    logic is_ctl, is_nl;
    always_comb
    begin
        code   = in_item.char_code;
        is_ctl = (code <= CH_C0MAX) || (code == CH_DEL) ||
                 ((code >= CH_C1MIN) && (code <= CH_C1MAX));
        is_nl  = (code == CH_LF) || (code == CH_VT) || (code == CH_FF) || (code == CH_NEL);
    end

    // memory port steering; reads use the cell address registered at take
    always_comb
    begin
        ram_we    = 1'b0;
        ram_waddr = sweep_reg;
        ram_wdata = {CH_SPACE, 11'd0, 64'd0};
        ram_raddr = {map_reg[rd_row_reg[RW-1:0]], rd_col_reg[CW-1:0]};
        priority if (state_reg == S_INIT)
        begin
            ram_we = 1'b1;
        end
        else if (state_reg == S_CLEAR)
        begin
            ram_we    = 1'b1;
            ram_waddr = {first_reg, idx_reg[CW-1:0]};
            ram_wdata = {CH_SPACE, 11'd0, fg_reg, bg_reg};
        end
        else if (take && in_item.req_type == REQ_PUT && (!is_ctl || code == CH_SUB))
        begin
            ram_we    = 1'b1;
            ram_waddr = {map_reg[crow[RW-1:0]], colidx({2'b0, ccol})};
            ram_wdata = {(code == CH_SUB) ? CH_QUERY : code, attr_reg, fg_reg, bg_reg};
        end
        else
        begin
        end
    end

    always_ff @(posedge clk)
    begin
        if (take)
        begin
            rd_row_reg <= {1'b0, qrow};
            rd_col_reg <= qcol[7:0];
        end
    end

    // main sequencer
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_INIT;
            sweep_reg     <= '0;
            col_reg       <= '0;
            row_reg       <= '0;
            idx_reg       <= '0;
            first_reg     <= '0;
            nl_first_reg  <= 1'b0;
            ny_reg        <= '0;
            out_valid_reg <= 1'b0;
            out_reg       <= '0;
            dirty_reg     <= '1;
            for (int i = 0; i < MAX_ROWS; i++)
            begin
                map_reg[i] <= RW'(i);
            end
        end
        else
        begin
            if (out_valid_reg && !out_stall)
            begin
                out_valid_reg <= 1'b0;
            end
            unique case (state_reg)
                S_INIT:
                begin
                    sweep_reg <= sweep_reg + 1'b1;
                    if (sweep_reg == AW'(DEPTH - 1))
                    begin
                        state_reg <= S_IDLE;
                    end
                end
                S_IDLE:
                begin
                    if (take)
                    begin
                        unique case (in_item.req_type)
                            REQ_PUT:
                            begin
                                out_reg <= '0;
                                col_reg <= ccol;
                                row_reg <= crow;
                                state_reg <= S_DONE;
                                if (!is_ctl)
                                begin
                                    dirty_reg[crow[RW-1:0]] <= 1'b1;
                                    if ({2'b0, ccol} + 9'd1 >= eff_cols)
                                    begin
                                        nl_first_reg <= 1'b1;
                                        ny_reg <= {2'b0, crow};
                                        state_reg <= S_ROT;
                                        idx_reg <= 7'h7f;
                                    end
                                    else
                                    begin
                                        col_reg <= ccol + 7'd1;
                                    end
                                end
                                else if (code == CH_SUB)
                                begin
                                    dirty_reg[crow[RW-1:0]] <= 1'b1;
                                end
                                else if (code == CH_BS)
                                begin
                                    col_reg <= (ccol == 7'd0) ? 7'd0 : ccol - 7'd1;
                                end
                                else if (code == CH_CR)
                                begin
                                    col_reg <= 7'd0;
                                end
                                else if (is_nl)
                                begin
                                    nl_first_reg <= (code == CH_NEL) || crlf_reg;
                                    ny_reg <= {2'b0, crow};
                                    state_reg <= S_ROT;
                                    idx_reg <= 7'h7f;
                                end
                                else
                                begin
                                end
                            end
                            REQ_READ:
                            begin
                                state_reg <= S_RWAIT;
                            end
                            REQ_ACK:
                            begin
                                out_reg.glyph_code       <= '0;
                                out_reg.glyph_attributes <= '0;
                                out_reg.glyph_foreground <= '0;
                                out_reg.glyph_background <= '0;
                                out_reg.line_dirty       <= dirty_reg[qrow[RW-1:0]];
                                dirty_reg[qrow[RW-1:0]] <= 1'b0;
                                state_reg <= S_DONE;
                            end
                            default:
                            begin
                                out_reg <= '0;
                                state_reg <= S_DONE;
                            end
                        endcase
                    end
                end
                S_RWAIT:
                begin
                    state_reg <= S_READ;
                end
                S_READ:
                begin
                    out_reg.glyph_code       <= ram_rdata[95:75];
                    out_reg.glyph_attributes <= ram_rdata[74:64];
                    out_reg.glyph_foreground <= ram_rdata[63:32];
                    out_reg.glyph_background <= ram_rdata[31:0];
                    out_reg.line_dirty       <= dirty_reg[rd_row_reg[RW-1:0]];
                    out_reg.cursor_x <= col_reg;
                    out_reg.cursor_y <= row_reg;
                    out_valid_reg <= 1'b1;
                    state_reg <= S_IDLE;
                end
                S_ROT:
                begin
                    // newline: scroll on the region bottom, else step down
                    if (ny_reg == ebot)
                    begin
                        first_reg <= map_reg[etop[RW-1:0]];
                        idx_reg   <= '0;
                        state_reg <= S_CLEAR;
                    end
                    else
                    begin
                        ny_reg <= (ny_reg + 7'd1 > rmax) ? rmax : ny_reg + 7'd1;
                        row_reg <= 5'((ny_reg + 7'd1 > rmax) ? rmax : ny_reg + 7'd1);
                        if (nl_first_reg)
                        begin
                            col_reg <= 7'd0;
                        end
                        dirty_reg[RW'((ny_reg + 7'd1 > rmax) ? rmax : ny_reg + 7'd1)] <= 1'b1;
                        state_reg <= S_DONE;
                    end
                end
                S_CLEAR:
                begin
                    // clear the leaving physical row, then rotate the map
                    if (idx_reg == CW'(MAX_COLUMNS - 1))
                    begin
                        for (int i = 0; i < MAX_ROWS; i++)
                        begin
                            if (7'(i) >= etop && 7'(i) < ebot)
                            begin
                                map_reg[i] <= map_reg[(i + 1) % MAX_ROWS];
                            end
                            if (7'(i) >= etop && 7'(i) <= ebot)
                            begin
                                dirty_reg[i] <= 1'b1;
                            end
                        end
                        map_reg[ebot[RW-1:0]] <= first_reg;
                        row_reg <= ebot[4:0];
                        if (nl_first_reg)
                        begin
                            col_reg <= 7'd0;
                        end
                        state_reg <= S_DONE;
                    end
                    idx_reg <= idx_reg + 7'd1;
                end
                S_DONE:
                begin
                    out_reg.cursor_x <= col_reg;
                    out_reg.cursor_y <= row_reg;
                    out_valid_reg <= 1'b1;
                    state_reg <= S_IDLE;
                end
                default:
                begin
                    state_reg <= S_IDLE;
                end
            endcase
        end
    end

    // checks
    a_no_take_busy: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg != S_IDLE) |-> in_stall)
        else $error("item taken while busy");
    a_out_from_done: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(out_valid) |-> ($past(state_reg) == S_DONE || $past(state_reg) == S_READ))
        else $error("result without completion");
    a_cursor_in_range: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_ROT) |-> ({2'b0, row_reg} <= rmax))
        else $error("cursor row out of range");
endmodule

[hdl/ttcw_ram.sv]
// Generic single-port-write, single-port-read RAM with registered read.
// No dependencies.
module ttcw_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);
    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end
endmodule

[tb/sv/text_terminal_character_writer_test.sv]
// Self-checking testbench for the character-cell screen writer.
// Depends on ttcw_pkg and the text_terminal_character_writer RTL.
`timescale 1ns / 1ps

module text_terminal_character_writer_test;
    import ttcw_pkg::*;

    localparam int ROWS = DEF_MAX_ROWS;
    localparam int COLS = DEF_MAX_COLUMNS;

    logic       clk;
    logic       rst_n;
    logic       cfg_we;
    logic [2:0] cfg_index;
    logic [31:0] cfg_data;
    logic       in_valid;
    logic       in_stall;
    req_item_t  in_item;
    logic       out_valid;
    logic       out_stall;
    rsp_item_t  out_item;

    text_terminal_character_writer u_dut (
        .clk(clk), .rst_n(rst_n),
        .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data),
        .in_valid(in_valid), .in_stall(in_stall), .in_item(in_item),
        .out_valid(out_valid), .out_stall(out_stall), .out_item(out_item)
    );

    always
    begin
        clk = 1'b0;
        #5;
        clk = 1'b1;
        #5;
    end

    // screen shadow
    logic [7:0]  sh_cols;
    logic [5:0]  sh_rows;
    logic [4:0]  sh_top;
    logic [4:0]  sh_bot;
    logic        sh_crlf;
    logic [10:0] sh_attr;
    logic [31:0] sh_fg;
    logic [31:0] sh_bg;
    logic [20:0] cell_code [ROWS*COLS];
    logic [10:0] cell_attr [ROWS*COLS];
    logic [31:0] cell_fg [ROWS*COLS];
    logic [31:0] cell_bg [ROWS*COLS];
    int          line_of [ROWS];
    bit          row_dirty [ROWS];
    int          cur_x;
    int          cur_y;

    rsp_item_t   expected_rsps[$];
    int          mismatches;
    bit          hold_off;
    bit          quiet;
    int          reads_seen;
    int          scrolls_seen;

    function automatic int rows_eff();
        return (sh_rows < 1) ? 1 : ((sh_rows > ROWS) ? ROWS : int'(sh_rows));
    endfunction

    function automatic int cols_eff();
        return (sh_cols < 1) ? 1 : ((sh_cols > COLS) ? COLS : int'(sh_cols));
    endfunction

    function automatic int bot_eff();
        return (sh_bot > rows_eff() - 1) ? rows_eff() - 1 : int'(sh_bot);
    endfunction

    function automatic int top_eff();
        return (sh_top > bot_eff()) ? bot_eff() : int'(sh_top);
    endfunction

    function automatic void store_cell(logic [20:0] code, logic [10:0] attr, int x, int y);
        int i;
        i = line_of[y] * COLS + x;
        cell_code[i] = code;
        cell_attr[i] = attr;
        cell_fg[i]   = sh_fg;
        cell_bg[i]   = sh_bg;
    endfunction

    function automatic void place_cursor(int x, int y);
        cur_x = (x > cols_eff() - 1) ? cols_eff() - 1 : x;
        cur_y = (y > rows_eff() - 1) ? rows_eff() - 1 : y;
    endfunction

    function automatic void line_feed(bit to_first);
        int y;
        int first;
        y = cur_y;
        if (y == bot_eff())
        begin
            scrolls_seen++;
            for (int x = 0; x < COLS; x++)
                store_cell(CH_SPACE, '0, x, top_eff());
            first = line_of[top_eff()];
            for (int i = top_eff(); i < bot_eff(); i++)
                line_of[i] = line_of[i + 1];
            line_of[bot_eff()] = first;
            for (int i = top_eff(); i <= bot_eff(); i++)
                row_dirty[i] = 1'b1;
        end
        else
            y++;
        place_cursor(to_first ? 0 : cur_x, y);
        row_dirty[cur_y] = 1'b1;
    endfunction

    function automatic void put_char(logic [20:0] code);
        if (cur_x > cols_eff() - 1) cur_x = cols_eff() - 1;
        if (cur_y > rows_eff() - 1) cur_y = rows_eff() - 1;
        if (code <= CH_C0MAX || code == CH_DEL || (code >= CH_C1MIN && code <= CH_C1MAX))
        begin
            case (code)
                CH_BS:  place_cursor((cur_x == 0) ? 0 : cur_x - 1, cur_y);
                CH_CR:  place_cursor(0, cur_y);
                CH_LF, CH_VT, CH_FF: line_feed(sh_crlf);
                CH_NEL: line_feed(1'b1);
                CH_SUB:
                begin
                    store_cell(CH_QUERY, sh_attr, cur_x, cur_y);
                    row_dirty[cur_y] = 1'b1;
                end
                default: ;
            endcase
        end
        else
        begin
            store_cell(code, sh_attr, cur_x, cur_y);
            row_dirty[cur_y] = 1'b1;
            if (cur_x + 1 >= cols_eff())
                line_feed(1'b1);
            else
                place_cursor(cur_x + 1, cur_y);
        end
    endfunction

    // predicted response for one accepted request
    function automatic rsp_item_t screen_response(req_item_t req);
        rsp_item_t r;
        int row;
        int col;
        int i;
        r = '0;
        row = (req.cell_row > rows_eff() - 1) ? rows_eff() - 1 : int'(req.cell_row);
        col = (req.cell_column > cols_eff() - 1) ? cols_eff() - 1 : int'(req.cell_column);
        if (req.req_type == REQ_PUT)
            put_char(req.char_code);
        else if (req.req_type == REQ_READ)
        begin
            i = line_of[row] * COLS + col;
            r.glyph_code       = cell_code[i];
            r.glyph_attributes = cell_attr[i];
            r.glyph_foreground = cell_fg[i];
            r.glyph_background = cell_bg[i];
            r.line_dirty       = row_dirty[row];
        end
        else if (req.req_type == REQ_ACK)
        begin
            r.line_dirty = row_dirty[row];
            row_dirty[row] = 1'b0;
        end
        r.cursor_x = cur_x[6:0];
        r.cursor_y = cur_y[4:0];
        return r;
    endfunction

    task automatic reset_shadow();
        sh_cols = 8'd80; sh_rows = 6'd24; sh_top = '0; sh_bot = 5'd23;
        sh_crlf = 1'b0; sh_attr = '0; sh_fg = '0; sh_bg = '0;
        for (int i = 0; i < ROWS*COLS; i++)
        begin
            cell_code[i] = CH_SPACE; cell_attr[i] = '0; cell_fg[i] = '0; cell_bg[i] = '0;
        end
        for (int i = 0; i < ROWS; i++)
        begin
            line_of[i] = i;
            row_dirty[i] = 1'b1;
        end
        cur_x = 0;
        cur_y = 0;
    endtask

    // one register write as a one-cycle enable pulse; the shadow follows once the enable is low again
    task automatic write_reg(logic [2:0] idx, logic [31:0] val);
        cfg_we    <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= val;
        @(posedge clk);
        cfg_we    <= 1'b0;
        @(posedge clk);
        case (idx)
            REG_COLUMNS: sh_cols = val[7:0];
            REG_ROWS:    sh_rows = val[5:0];
            REG_TOP:     sh_top  = val[4:0];
            REG_BOTTOM:  sh_bot  = val[4:0];
            REG_CRLF:    sh_crlf = val[0];
            REG_ATTR:    sh_attr = val[10:0];
            REG_FG:      sh_fg   = val;
            REG_BG:      sh_bg   = val;
            default: ;
        endcase
    endtask

    // every request yields one response; wait for them, then a quiet margin
    task automatic drain();
        in_valid <= 1'b0;
        while (expected_rsps.size() != 0)
            @(posedge clk);
        repeat (300) @(posedge clk);
    endtask

    // offer one request and hold it until taken
    task automatic send(req_item_t req, bit may_idle);
        while (may_idle && !quiet && $urandom_range(99) < 10)
        begin
            in_valid <= 1'b0;
            @(posedge clk);
        end
        in_valid <= 1'b1;
        in_item  <= req;
        @(posedge clk);
        while (in_stall)
            @(posedge clk);
        expected_rsps.push_back(screen_response(req));
        if (req.req_type == REQ_READ) reads_seen++;
    endtask

    function automatic req_item_t random_req();
        req_item_t q;
        int pick;
        q = '0;
        pick = $urandom_range(99);
        q.cell_row    = 5'($urandom_range(31));
        q.cell_column = 7'($urandom_range(127));
        if (pick < 60)
        begin
            q.req_type = REQ_PUT;
            case ($urandom_range(9))
                0: q.char_code = CH_LF;
                1: q.char_code = CH_NEL;
                2: q.char_code = 21'($urandom_range(31));
                3: q.char_code = 21'($urandom_range(CH_C1MAX, CH_C1MIN));
                4: q.char_code = 21'($urandom_range(21'h1fffff));
                5: q.char_code = $urandom_range(2) == 0 ? CH_BS : CH_CR;
                default: q.char_code = 21'($urandom_range(21'h7e, 21'h21));
            endcase
        end
        else if (pick < 82)
            q.req_type = REQ_READ;
        else if (pick < 97)
            q.req_type = REQ_ACK;
        else
        begin
            q.req_type  = 2'd3;
            q.char_code = 21'($urandom_range(21'h1fffff));
        end
        return q;
    endfunction

    // receiver: random stalls, long hold-off when asked
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_stall <= 1'b0;
        else
            out_stall <= hold_off || (!quiet && $urandom_range(99) < 10);
    end

    // response checker
    always @(posedge clk)
    begin
        if (rst_n && out_valid && !out_stall)
        begin
            if (expected_rsps.size() == 0)
            begin
                mismatches++;
                if (mismatches <= 10)
                    $display("unexpected response %h", out_item);
            end
            else
            begin
                rsp_item_t e;
                e = expected_rsps.pop_front();
                if (out_item !== e)
                begin
                    mismatches++;
                    if (mismatches <= 10)
                        $display("response mismatch: expected %h, got %h", e, out_item);
                end
            end
        end
    end

    // directed table: item, expected response where obvious, check flag
    typedef struct {
        req_item_t  req;
        rsp_item_t  rsp;
        bit         known;
    } directed_row_t;

    directed_row_t directed [$];

    function automatic req_item_t mk(logic [1:0] t, logic [20:0] c, logic [4:0] r, logic [6:0] col);
        req_item_t q;
        q.req_type = t; q.char_code = c; q.cell_row = r; q.cell_column = col;
        return q;
    endfunction

    function automatic rsp_item_t glyph_rsp(logic [20:0] c, logic d);
        rsp_item_t r;
        r = '0;
        r.glyph_code = c;
        r.line_dirty = d;
        return r;
    endfunction

    initial
    begin
        #20_000_000;
        $display("text_terminal_character_writer: mismatch");
        $finish;
    end

    initial
    begin
        rsp_item_t got;
        rst_n = 1'b0;
        cfg_we = 1'b0; cfg_index = '0; cfg_data = '0;
        in_valid = 1'b0; in_item = '0;
        hold_off = 1'b0; quiet = 1'b0;
        mismatches = 0; reads_seen = 0; scrolls_seen = 0;
        reset_shadow();
        repeat (11) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // after reset: blank cell, dirty row; extremes of row and column clamp
        directed.push_back('{mk(REQ_READ, 0, 0, 0), glyph_rsp(CH_SPACE, 1), 1});
        directed.push_back('{mk(REQ_READ, 0, 31, 127), glyph_rsp(CH_SPACE, 1), 1});
        directed.push_back('{mk(REQ_ACK, 0, 31, 0), glyph_rsp(0, 1), 1});
        directed.push_back('{mk(REQ_ACK, 0, 23, 0), glyph_rsp(0, 0), 1});
        directed.push_back('{mk(2'd3, 21'h1fffff, 31, 127), '0, 1});
        directed.push_back('{mk(REQ_PUT, 21'h41, 0, 0), '0, 0});
        directed.push_back('{mk(REQ_PUT, 21'h1fffff, 0, 0), '0, 0});
        directed.push_back('{mk(REQ_PUT, CH_BS, 0, 0), '0, 0});
        directed.push_back('{mk(REQ_PUT, CH_SUB, 0, 0), '0, 0});
        directed.push_back('{mk(REQ_PUT, CH_CR, 0, 0), '0, 0});
        directed.push_back('{mk(REQ_PUT, CH_BS, 0, 0), '0, 0});
        directed.push_back('{mk(REQ_PUT, CH_LF, 0, 0), '0, 0});
        directed.push_back('{mk(REQ_PUT, CH_VT, 0, 0), '0, 0});
        directed.push_back('{mk(REQ_PUT, CH_FF, 0, 0), '0, 0});
        directed.push_back('{mk(REQ_PUT, CH_NEL, 0, 0), '0, 0});
        directed.push_back('{mk(REQ_PUT, CH_DEL, 0, 0), '0, 0});
        directed.push_back('{mk(REQ_PUT, CH_C1MAX, 0, 0), '0, 0});
        directed.push_back('{mk(REQ_PUT, CH_C1MIN, 0, 0), '0, 0});
        directed.push_back('{mk(REQ_PUT, 21'h1b, 0, 0), '0, 0});
        directed.push_back('{mk(REQ_PUT, 21'ha0, 0, 0), '0, 0});
        directed.push_back('{mk(REQ_READ, 0, 0, 0), '0, 0});
        directed.push_back('{mk(REQ_READ, 0, 0, 1), '0, 0});
        directed.push_back('{mk(REQ_READ, 0, 3, 0), '0, 0});

        foreach (directed[i])
        begin
            send(directed[i].req, 1'b0);
            if (directed[i].known)
            begin
                // the prediction just queued for this row
                got = expected_rsps[$];
                if (got !== directed[i].rsp)
                begin
                    mismatches++;
                    if (mismatches <= 10)
                        $display("table row %0d: model gives %h, table %h", i, got, directed[i].rsp);
                end
            end
        end
        drain();

        // phases of configuration, extremes included
        for (int ph = 0; ph < 6; ph++)
        begin
            case (ph)
                0: begin
                    write_reg(REG_COLUMNS, 8); write_reg(REG_ROWS, 4);
                    write_reg(REG_TOP, 1); write_reg(REG_BOTTOM, 2);
                    write_reg(REG_CRLF, 0); write_reg(REG_ATTR, 32'h7ff);
                    write_reg(REG_FG, 32'hffffffff); write_reg(REG_BG, 32'h12345678);
                end
                1: begin
                    write_reg(REG_COLUMNS, 0); write_reg(REG_ROWS, 0);
                    write_reg(REG_TOP, 31); write_reg(REG_BOTTOM, 31);
                    write_reg(REG_CRLF, 1); write_reg(REG_ATTR, 0);
                    write_reg(REG_FG, 0); write_reg(REG_BG, 32'hffffffff);
                end
                2: begin
                    write_reg(REG_COLUMNS, 255); write_reg(REG_ROWS, 63);
                    write_reg(REG_TOP, 0); write_reg(REG_BOTTOM, 31);
                    write_reg(REG_ATTR, 32'h2aa);
                end
                3: begin
                    write_reg(REG_COLUMNS, 1); write_reg(REG_ROWS, 32);
                    write_reg(REG_TOP, 5); write_reg(REG_BOTTOM, 3);
                    write_reg(REG_CRLF, 0);
                end
                default: begin
                    write_reg(REG_COLUMNS, $urandom_range(2, 20));
                    write_reg(REG_ROWS, $urandom_range(2, 8));
                    write_reg(REG_TOP, $urandom_range(3));
                    write_reg(REG_BOTTOM, $urandom_range(2, 7));
                    write_reg(REG_CRLF, $urandom_range(1));
                    write_reg(REG_ATTR, $urandom_range(11'h7ff));
                    write_reg(REG_FG, $urandom);
                    write_reg(REG_BG, $urandom);
                end
            endcase
            quiet = (ph == 2);
            for (int k = 0; k < 65; k++)
            begin
                // long receiver hold-off while requests keep coming
                if (ph == 1 && k == 10)
                    fork
                        begin
                            hold_off = 1'b1;
                            repeat (400) @(posedge clk);
                            hold_off = 1'b0;
                        end
                    join_none
                send(random_req(), 1'b1);
            end
            quiet = 1'b0;
            // sender waits for every response before the next setting
            drain();
        end

        $display("covered %0d cell reads and %0d scrolls over six register settings",
                 reads_seen, scrolls_seen);
        if (mismatches == 0)
            $display("text_terminal_character_writer: match");
        else
            $display("text_terminal_character_writer: mismatch");
        $finish;
    end

endmodule

[text_terminal_character_writer.f]
hdl/ttcw_pkg.sv
hdl/ttcw_ram.sv
hdl/text_terminal_character_writer.sv
tb/sv/text_terminal_character_writer_test.sv
